### sv/terminal_key_sequence_decoder_assert.svh
`ifndef TERMINAL_KEY_SEQUENCE_DECODER_ASSERT_SVH
`define TERMINAL_KEY_SEQUENCE_DECODER_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define TKSD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define TKSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/tksd_pkg.sv
`timescale 1ns / 1ps

package tksd_pkg;

  localparam int NumSeq   = 10;
  localparam int SeqMax   = 5;
  localparam int ActWidth = 5;

  typedef logic [ActWidth-1:0] action_t;
  typedef logic [NumSeq-1:0]   seq_mask_t;

  localparam logic [7:0] KeyEsc = 8'h1B;

  localparam action_t ActNone      = 5'd0;
  localparam action_t ActCutEnd    = 5'd1;
  localparam action_t ActCutStart  = 5'd2;
  localparam action_t ActCutWord   = 5'd3;
  localparam action_t ActHome      = 5'd4;
  localparam action_t ActEnd       = 5'd5;
  localparam action_t ActDelete    = 5'd6;
  localparam action_t ActBackspace = 5'd7;
  localparam action_t ActCtrlX     = 5'd8;
  localparam action_t ActCtrlP     = 5'd9;
  localparam action_t ActRight     = 5'd10;
  localparam action_t ActUp        = 5'd11;
  localparam action_t ActLeft      = 5'd12;
  localparam action_t ActDown      = 5'd13;
  localparam action_t ActWordLeft  = 5'd14;
  localparam action_t ActWordRight = 5'd15;
  localparam action_t ActCutWordFw = 5'd16;
  localparam action_t ActJumpUp    = 5'd17;
  localparam action_t ActJumpDown  = 5'd18;
  localparam action_t ActBell      = 5'd19;
  localparam action_t ActPending   = 5'd20;

  localparam logic [7:0] SeqBytes [NumSeq][SeqMax] = '{
    '{8'h5B, 8'h43, 8'h00, 8'h00, 8'h00},  // [C
    '{8'h5B, 8'h41, 8'h00, 8'h00, 8'h00},  // [A
    '{8'h5B, 8'h44, 8'h00, 8'h00, 8'h00},  // [D
    '{8'h5B, 8'h42, 8'h00, 8'h00, 8'h00},  // [B
    '{8'h5B, 8'h33, 8'h7E, 8'h00, 8'h00},  // [3~
    '{8'h62, 8'h00, 8'h00, 8'h00, 8'h00},  // b
    '{8'h66, 8'h00, 8'h00, 8'h00, 8'h00},  // f
    '{8'h64, 8'h00, 8'h00, 8'h00, 8'h00},  // d
    '{8'h5B, 8'h31, 8'h3B, 8'h35, 8'h41},  // [1;5A
    '{8'h5B, 8'h31, 8'h3B, 8'h35, 8'h42}   // [1;5B
  };

  localparam logic [2:0] SeqLen [NumSeq] = '{
    3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd1, 3'd1, 3'd1, 3'd5, 3'd5
  };

  localparam action_t SeqAction [NumSeq] = '{
    ActRight, ActUp, ActLeft, ActDown, ActDelete,
    ActWordLeft, ActWordRight, ActCutWordFw, ActJumpUp, ActJumpDown
  };

  // Action for a byte received outside an escape sequence.
  function automatic action_t idle_action(logic [7:0] b);
    action_t act;
    unique case (b)
      8'h0B:   act = ActCutEnd;
      8'h15:   act = ActCutStart;
      8'h17:   act = ActCutWord;
      8'h01:   act = ActHome;
      8'h05:   act = ActEnd;
      8'h04:   act = ActDelete;
      8'h7F:   act = ActBackspace;
      8'h08:   act = ActBackspace;
      8'h18:   act = ActCtrlX;
      8'h10:   act = ActCtrlP;
      default: act = ActNone;
    endcase
    return act;
  endfunction

endpackage

### sv/terminal_key_sequence_decoder.sv
`timescale 1ns / 1ps

// Each input transfer loads its action into the output register.
// Throughput: one byte per cycle if not stalled; all ten sequences are matched in parallel.
// A byte is taken whenever the output register is empty or is being drained that cycle.
// Reset (rst_ni low, asynchronous): idle mode, candidate mask all ones, no output pending.
module terminal_key_sequence_decoder (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 key_valid_i,
  output logic                 key_ready_o,
  input  logic [7:0]           key_byte_i,
  output logic                 action_valid_o,
  input  logic                 action_ready_i,
  output tksd_pkg::action_t    action_o
);

  logic                  in_escape_q, in_escape_d;
  logic [2:0]            matched_count_q, matched_count_d;
  tksd_pkg::seq_mask_t   candidate_mask_q, candidate_mask_d;
  logic                  out_valid_q;
  tksd_pkg::action_t     action_q, action_d;

  tksd_pkg::seq_mask_t   hit;
  logic                  done;
  tksd_pkg::action_t     done_action;
  logic                  key_xfer;

  assign key_ready_o    = !out_valid_q || action_ready_i;
  assign key_xfer       = key_valid_i && key_ready_o;
  assign action_valid_o = out_valid_q;
  assign action_o       = action_q;

  always_comb begin
    done        = 1'b0;
    done_action = tksd_pkg::ActNone;
    for (int k = 0; k < tksd_pkg::NumSeq; k++) begin
      if (candidate_mask_q[k] && (matched_count_q < tksd_pkg::SeqLen[k]) &&
          (int'(matched_count_q) < tksd_pkg::SeqMax)) begin
        hit[k] = (tksd_pkg::SeqBytes[k][matched_count_q] == key_byte_i);
      end else begin
        hit[k] = 1'b0;
      end
    end
    // The lowest-numbered sequence that completes on this byte wins.
    for (int k = tksd_pkg::NumSeq - 1; k >= 0; k--) begin
      if (hit[k] && ({1'b0, tksd_pkg::SeqLen[k]} == ({1'b0, matched_count_q} + 4'd1))) begin
        done        = 1'b1;
        done_action = tksd_pkg::SeqAction[k];
      end
    end
  end

  always_comb begin
    in_escape_d      = in_escape_q;
    matched_count_d  = matched_count_q;
    candidate_mask_d = candidate_mask_q;
    if (!in_escape_q) begin
      if (key_byte_i == tksd_pkg::KeyEsc) begin
        in_escape_d      = 1'b1;
        matched_count_d  = 3'd0;
        candidate_mask_d = '1;
        action_d         = tksd_pkg::ActPending;
      end else begin
        action_d = tksd_pkg::idle_action(key_byte_i);
      end
    end else if (hit == '0) begin
      in_escape_d      = 1'b0;
      matched_count_d  = 3'd0;
      candidate_mask_d = '1;
      action_d         = tksd_pkg::ActBell;
    end else if (done) begin
      in_escape_d      = 1'b0;
      matched_count_d  = 3'd0;
      candidate_mask_d = '1;
      action_d         = done_action;
    end else begin
      candidate_mask_d = hit;
      matched_count_d  = matched_count_q + 3'd1;
      action_d         = tksd_pkg::ActPending;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_escape_q      <= 1'b0;
      matched_count_q  <= 3'd0;
      candidate_mask_q <= '1;
      out_valid_q      <= 1'b0;
    end else begin
      if (key_xfer) begin
        in_escape_q      <= in_escape_d;
        matched_count_q  <= matched_count_d;
        candidate_mask_q <= candidate_mask_d;
        out_valid_q      <= 1'b1;
      end else if (action_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_xfer) begin
      action_q <= action_d;
    end
  end

endmodule

### sv/tksd_monitor.sv
`timescale 1ns / 1ps

`include "terminal_key_sequence_decoder_assert.svh"

module tksd_monitor (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              key_valid_i,
  input logic              key_ready_o,
  input logic              action_valid_o,
  input logic              action_ready_i,
  input tksd_pkg::action_t action_o
);

  // A stalled action stays on the port unchanged.
  `TKSD_ASSERT_NEXT(a_out_hold, action_valid_o && !action_ready_i,
    action_valid_o && $stable(action_o), "action changed or dropped while stalled")

  `TKSD_ASSERT_NOW(a_code_range, action_valid_o, action_o <= tksd_pkg::ActPending,
    "action code out of range")

  // Every byte transfer is followed by a valid action on the following cycle.
  `TKSD_ASSERT_NEXT(a_one_result, key_valid_i && key_ready_o, action_valid_o,
    "byte transfer without a following action")

  `TKSD_ASSERT_NEXT(a_no_invent,
    !(key_valid_i && key_ready_o) && action_valid_o && action_ready_i, !action_valid_o,
    "action appeared without a byte transfer")

endmodule

bind terminal_key_sequence_decoder tksd_monitor u_tksd_monitor (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .key_valid_i    (key_valid_i),
  .key_ready_o    (key_ready_o),
  .action_valid_o (action_valid_o),
  .action_ready_i (action_ready_i),
  .action_o       (action_o)
);

### bench/tksd_action_checker.sv
`timescale 1ns / 1ps

module tksd_action_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              key_valid_i,
  input  logic              key_ready_o,
  input  logic [7:0]        key_byte_i,
  input  logic              action_valid_o,
  input  logic              action_ready_i,
  input  tksd_pkg::action_t action_o,
  output int                fail_count,
  output int                outstanding
);

  localparam logic [7:0] KeyCtrlA  = 8'h01;
  localparam logic [7:0] KeyCtrlD  = 8'h04;
  localparam logic [7:0] KeyCtrlE  = 8'h05;
  localparam logic [7:0] KeyCtrlH  = 8'h08;
  localparam logic [7:0] KeyCtrlK  = 8'h0B;
  localparam logic [7:0] KeyCtrlP  = 8'h10;
  localparam logic [7:0] KeyCtrlU  = 8'h15;
  localparam logic [7:0] KeyCtrlW  = 8'h17;
  localparam logic [7:0] KeyCtrlX  = 8'h18;
  localparam logic [7:0] KeyDelete = 8'h7F;

  // Decoder state as the bytes seen so far leave it.
  logic                esc_mode;
  logic [2:0]          match_pos;
  tksd_pkg::seq_mask_t live_seqs;

  tksd_pkg::action_t   expected_actions[$];

  function automatic tksd_pkg::action_t decode_key_byte(logic [7:0] kb);
    tksd_pkg::seq_mask_t hits;
    tksd_pkg::action_t   act;
    hits = '0;
    act  = tksd_pkg::ActNone;
    if (!esc_mode) begin
      if (kb == tksd_pkg::KeyEsc) begin
        esc_mode  = 1'b1;
        match_pos = 3'd0;
        live_seqs = '1;
        act       = tksd_pkg::ActPending;
      end else begin
        case (kb)
          KeyCtrlK:           act = tksd_pkg::ActCutEnd;
          KeyCtrlU:           act = tksd_pkg::ActCutStart;
          KeyCtrlW:           act = tksd_pkg::ActCutWord;
          KeyCtrlA:           act = tksd_pkg::ActHome;
          KeyCtrlE:           act = tksd_pkg::ActEnd;
          KeyCtrlD:           act = tksd_pkg::ActDelete;
          KeyDelete, KeyCtrlH: act = tksd_pkg::ActBackspace;
          KeyCtrlX:           act = tksd_pkg::ActCtrlX;
          KeyCtrlP:           act = tksd_pkg::ActCtrlP;
          default:            act = tksd_pkg::ActNone;
        endcase
      end
    end else begin
      for (int k = 0; k < tksd_pkg::NumSeq; k++) begin
        if (live_seqs[k] && match_pos < tksd_pkg::SeqLen[k] &&
            tksd_pkg::SeqBytes[k][match_pos] == kb) begin
          hits[k] = 1'b1;
        end
      end
      if (hits == '0) begin
        act = tksd_pkg::ActBell;
      end else begin
        act = tksd_pkg::ActPending;
        // Walk downward so the lowest-numbered complete sequence wins.
        for (int k = tksd_pkg::NumSeq - 1; k >= 0; k--) begin
          if (hits[k] && tksd_pkg::SeqLen[k] == match_pos + 3'd1) begin
            act = tksd_pkg::SeqAction[k];
          end
        end
      end
      if (act == tksd_pkg::ActPending) begin
        live_seqs = hits;
        match_pos = match_pos + 3'd1;
      end else begin
        esc_mode  = 1'b0;
        match_pos = 3'd0;
        live_seqs = '1;
      end
    end
    return act;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tksd_pkg::action_t exp_act;
    if (!rst_ni) begin
      esc_mode   = 1'b0;
      match_pos  = 3'd0;
      live_seqs  = '1;
      fail_count = 0;
      expected_actions.delete();
    end else begin
      // A result leaves in the cycle after its byte at the earliest, so pop before push.
      if (action_valid_o && action_ready_i) begin
        if (expected_actions.size() == 0) begin
          $error("action transfer with no byte pending: actual %0d", action_o);
          fail_count++;
        end else begin
          exp_act = expected_actions.pop_front();
          if (action_o !== exp_act) begin
            $error("action mismatch: expected %0d, actual %0d", exp_act, action_o);
            fail_count++;
          end
        end
      end
      if (key_valid_i && key_ready_o) begin
        expected_actions.push_back(decode_key_byte(key_byte_i));
      end
    end
    outstanding = expected_actions.size();
  end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int NumBytes   = 1200;
  localparam int CycleLimit = 200000;

  // The ten bytes that map to an action outside an escape sequence.
  localparam logic [7:0] CtrlKeys [10] = '{
    8'h0B, 8'h15, 8'h17, 8'h01, 8'h05, 8'h04, 8'h7F, 8'h08, 8'h18, 8'h10
  };

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              key_valid_i    = 1'b0;
  logic [7:0]        key_byte_i     = 8'h00;
  logic              action_ready_i = 1'b0;
  logic              key_ready_o;
  logic              action_valid_o;
  tksd_pkg::action_t action_o;

  int fail_count;
  int outstanding;
  int cycle_count = 0;
  int sent_bytes  = 0;
  int burst_left  = 0;
  int ready_phase_left = 0;
  logic [7:0] ready_bits = 8'hFF;

  terminal_key_sequence_decoder dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .key_valid_i    (key_valid_i),
    .key_ready_o    (key_ready_o),
    .key_byte_i     (key_byte_i),
    .action_valid_o (action_valid_o),
    .action_ready_i (action_ready_i),
    .action_o       (action_o)
  );

  tksd_action_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .key_valid_i    (key_valid_i),
    .key_ready_o    (key_ready_o),
    .key_byte_i     (key_byte_i),
    .action_valid_o (action_valid_o),
    .action_ready_i (action_ready_i),
    .action_o       (action_o),
    .fail_count     (fail_count),
    .outstanding    (outstanding)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // The receiver switches between always ready, a random mask and a sparse
  // mask, each rotated one bit per cycle.
  always @(negedge clk_i) begin
    if (ready_phase_left == 0) begin
      ready_phase_left = $urandom_range(20, 120);
      case ($urandom_range(0, 2))
        0:       ready_bits = 8'hFF;
        1:       ready_bits = 8'($urandom);
        default: ready_bits = 8'h11;
      endcase
    end else begin
      ready_phase_left--;
    end
    ready_bits = {ready_bits[6:0], ready_bits[7]};
    action_ready_i <= ready_bits[0];
  end

  // Called at a falling edge; returns at a falling edge after the transfer.
  task automatic send_byte(input logic [7:0] b);
    key_valid_i <= 1'b1;
    key_byte_i  <= b;
    @(posedge clk_i);
    while (!key_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    sent_bytes++;
    if (burst_left == 0) begin
      key_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
  endtask

  // A broken sequence stops early and ends in an arbitrary byte.
  task automatic send_escape(input int k, input bit broken);
    int cut;
    cut = broken ? $urandom_range(0, tksd_pkg::SeqLen[k] - 1) : tksd_pkg::SeqLen[k];
    send_byte(tksd_pkg::KeyEsc);
    for (int i = 0; i < cut; i++) send_byte(tksd_pkg::SeqBytes[k][i]);
    if (broken) send_byte(8'($urandom_range(0, 255)));
  endtask

  initial begin
    int sel;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: byte extremes, a long sequence, ESC and zero inside a
    // sequence, the shared delete and an ordinary idle byte.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_escape(8, 1'b0);
    send_escape(4, 1'b0);
    send_byte(tksd_pkg::KeyEsc);
    send_byte(tksd_pkg::KeyEsc);
    send_byte(tksd_pkg::KeyEsc);
    send_byte(8'h00);
    send_escape(5, 1'b0);
    send_byte(8'h04);
    send_byte(8'h7F);
    send_byte(8'h08);
    send_byte(8'h41);

    while (sent_bytes < NumBytes) begin
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        send_escape($urandom_range(0, tksd_pkg::NumSeq - 1), $urandom_range(0, 4) == 0);
      end else if (sel < 80) begin
        send_byte(CtrlKeys[$urandom_range(0, 9)]);
      end else if (sel < 90) begin
        send_byte(tksd_pkg::KeyEsc);
        send_byte(8'($urandom_range(0, 255)));
      end else begin
        send_byte(8'($urandom_range(0, 255)));
      end
    end

    key_valid_i <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
